// ----- hdl/eccp_pkg.sv -----
// Package for the escape-count colour palette: widths, palette codes, channel scales.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package eccp_pkg;
	localparam int CfgWidth = 16;
	localparam int CfgIndexWidth = 1;
	localparam int ColourWidth = 28;
	localparam logic [CfgIndexWidth-1:0] REG_MAX_ITER = 1'd0;
	localparam logic [CfgIndexWidth-1:0] REG_PALETTE = 1'd1;
	localparam logic [1:0] PAL_WARM = 2'd0;
	localparam logic [1:0] PAL_COOL = 2'd1;
	localparam logic [13:0] RED_K2 = 14'd4590;
	localparam logic [13:0] GREEN_K2 = 14'd7650;
	localparam logic [13:0] BLUE_K2 = 14'd4335;
	typedef logic [1:0] mode_t;
endpackage
`default_nettype wire

// ----- hdl/eccp_stream_if.sv -----
// Valid/ready stream interface carrying one payload word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface eccp_stream_if #(parameter int W = 16);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/escape_count_colour_palette_core.sv -----
// Throughput: one word per clock; a stall freezes all stages. The pipeline depth is set
// by the bit-per-stage restoring divider and square root.
// Reset clears valid bits and loads max_iterations = 100, palette_mode = 0.
// Uses eccp_pkg and eccp_stream_if.
`timescale 1ns / 1ps
`default_nettype none
module escape_count_colour_palette_core #(
	parameter int COUNT_WIDTH = 16,
	parameter int FRACTION_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [eccp_pkg::CfgIndexWidth-1:0] cfg_index,
	input wire logic [eccp_pkg::CfgWidth-1:0] cfg_data,
	eccp_stream_if.sink in_s,
	eccp_stream_if.source out_s
);
	import eccp_pkg::*;
	localparam int F = FRACTION_BITS;
	localparam int CW = COUNT_WIDTH;
	localparam int DS = 2 * F;          // divider stages
	localparam int SS = F;              // sqrt stages
	localparam int RW = CW + 1;         // remainder width
	localparam int NS = DS + SS + 7;
	localparam int PW = F + 1;          // fraction plus integer one

	logic [CW-1:0] max_q;
	mode_t mode_q;
	logic adv;
	logic [NS-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= CW'(100);
			mode_q <= PAL_WARM;
		end else if (cfg_we) begin
			if (cfg_index == REG_MAX_ITER) max_q <= CW'(cfg_data);
			else if (cfg_index == REG_PALETTE) mode_q <= cfg_data[1:0];
		end
	end

	// whole pipe advances unless output is held
	assign adv = !out_s.valid || out_s.ready;
	assign in_s.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[NS-2:0], in_s.valid};
	end

	// divider: remainder and quotient per stage, black flag rides along
	logic [RW-1:0] rem_q [DS+1];
	logic [DS-1:0] quo_q [DS+1];
	logic blk_q [DS+1];
	logic [CW-1:0] in_cnt;
	assign in_cnt = in_s.data[CW-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_q[0] <= RW'(in_cnt >= max_q ? max_q : in_cnt);
			quo_q[0] <= '0;
			blk_q[0] <= in_cnt >= max_q;
		end
	end

	for (genvar i = 0; i < DS; i++) begin : g_div
		logic [RW-1:0] sh;
		assign sh = {rem_q[i][RW-2:0], 1'b0};
		always_ff @(posedge clk) begin
			if (adv) begin
				if (sh >= RW'(max_q)) begin
					rem_q[i+1] <= sh - RW'(max_q);
					quo_q[i+1] <= {quo_q[i][DS-2:0], 1'b1};
				end else begin
					rem_q[i+1] <= sh;
					quo_q[i+1] <= {quo_q[i][DS-2:0], 1'b0};
				end
				blk_q[i+1] <= blk_q[i];
			end
		end
	end

	// square root: digit-by-digit, one result bit per stage
	logic [DS:0] sv_q [1:SS];
	logic [DS:0] sr_q [1:SS];
	logic sblk_q [1:SS];
	for (genvar j = 0; j < SS; j++) begin : g_sqrt
		localparam logic [DS:0] BIT = (DS+1)'(1) << (DS - 2 - 2 * j);
		logic [DS:0] v_in;
		logic [DS:0] r_in;
		logic b_in;
		if (j == 0) begin : g_first
			assign v_in = {1'b0, quo_q[DS]};
			assign r_in = '0;
			assign b_in = blk_q[DS];
		end else begin : g_next
			assign v_in = sv_q[j];
			assign r_in = sr_q[j];
			assign b_in = sblk_q[j];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				if (v_in >= r_in + BIT) begin
					sv_q[j+1] <= v_in - (r_in + BIT);
					sr_q[j+1] <= (r_in >> 1) + BIT;
				end else begin
					sv_q[j+1] <= v_in;
					sr_q[j+1] <= r_in >> 1;
				end
				sblk_q[j+1] <= b_in;
			end
		end
	end

	// polynomial stages
	logic [PW-1:0] t_s1, u_s1, t_s2, u_s2, t2_s2, u2_s2, t_s3, u_s3, t2_s3, u2_s3;
	logic [PW-1:0] t3_s3, u3_s3, pr_s4, pg_s4, pb_s4;
	logic [PW+13:0] r_s5, g_s5, b_s5;
	logic blk_s1, blk_s2, blk_s3, blk_s4, blk_s5;
	logic [ColourWidth-1:0] col_q;

	function automatic logic [PW-1:0] fxm(input logic [PW-1:0] a, input logic [PW-1:0] b);
		logic [2*PW-1:0] p;
		p = a * b;
		return PW'(p >> F);
	endfunction

	logic [PW-1:0] tt;
	assign tt = PW'(sr_q[SS]);

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1 <= tt;
			u_s1 <= (PW'(1) << F) - tt;
			blk_s1 <= sblk_q[SS];
			t_s2 <= t_s1; u_s2 <= u_s1;
			t2_s2 <= fxm(t_s1, t_s1);
			u2_s2 <= fxm(u_s1, u_s1);
			blk_s2 <= blk_s1;
			t_s3 <= t_s2; u_s3 <= u_s2; t2_s3 <= t2_s2; u2_s3 <= u2_s2;
			t3_s3 <= fxm(t2_s2, t_s2);
			u3_s3 <= fxm(u2_s2, u_s2);
			blk_s3 <= blk_s2;
			unique case (mode_q)
				PAL_WARM: begin
					pr_s4 <= fxm(t3_s3, u_s3);
					pg_s4 <= fxm(u2_s3, t2_s3);
					pb_s4 <= fxm(u3_s3, t_s3);
				end
				PAL_COOL: begin
					pr_s4 <= fxm(u2_s3, t_s3);
					pg_s4 <= fxm(u_s3, t2_s3);
					pb_s4 <= t3_s3;
				end
				default: begin
					pr_s4 <= t2_s3;
					pg_s4 <= fxm(u_s3, t_s3);
					pb_s4 <= u2_s3;
				end
			endcase
			blk_s4 <= blk_s3;
			r_s5 <= pr_s4 * RED_K2;
			g_s5 <= pg_s4 * GREEN_K2;
			b_s5 <= pb_s4 * BLUE_K2;
			blk_s5 <= blk_s4;
			if (blk_s5) col_q <= '0;
			else col_q <= (ColourWidth'(r_s5 >> (F + 1)) << 16)
				| (ColourWidth'(g_s5 >> (F + 1)) << 8) | ColourWidth'(b_s5 >> (F + 1));
		end
	end

	assign out_s.valid = vld_q[NS-1];
	assign out_s.data = col_q;

	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_s.valid && !out_s.ready |=> out_s.valid && $stable(out_s.data))
		else $error("result changed under stall");
	ap_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_s.valid |-> in_s.ready) else $error("stall with empty output");
	ap_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!in_s.ready |=> $stable(vld_q)) else $error("pipe moved during stall");
endmodule
`default_nettype wire

// ----- test/tb_escape_count_colour_palette_core.sv -----
// Testbench for escape_count_colour_palette_core: drives iteration counts, predicts packed
// colours per palette and limit, and checks every output word in order.
// Depends on eccp_pkg, eccp_stream_if and the core.
`timescale 1ns / 1ps
module tb_escape_count_colour_palette_core;
	import eccp_pkg::*;

	localparam int FB = 16;
	localparam int LATENCY = 3 * FB + 7;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CfgIndexWidth-1:0] cfg_index;
	logic [CfgWidth-1:0] cfg_data;

	eccp_stream_if #(.W(16)) in_s ();
	eccp_stream_if #(.W(ColourWidth)) out_s ();

	escape_count_colour_palette_core i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_s(in_s.sink), .out_s(out_s.source)
	);

	logic [15:0] limit_q;
	mode_t palette_q;
	logic [ColourWidth-1:0] colour_q[$];
	int errors;
	int words_sent;
	int words_checked;
	bit idle_en;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("tb_escape_count_colour_palette_core failed");
		$finish;
	end

	function automatic logic [63:0] fmul(logic [63:0] a, logic [63:0] b);
		return (a * b) >> FB;
	endfunction

	function automatic logic [63:0] scale(logic [63:0] p, logic [63:0] k2);
		return (p * k2) >> (FB + 1);
	endfunction

	// t = floor(sqrt(count * 2^(2F) / limit)), then the selected palette
	function automatic logic [ColourWidth-1:0] colour_of(logic [15:0] cnt);
		logic [63:0] c, q, v, res, bitv, t, u, t2, u2, r, g, b;
		c = cnt;
		if (c > limit_q) c = limit_q;
		if (c == limit_q) return '0;
		q = (c << (2 * FB)) / limit_q;
		v = q;
		res = 0;
		bitv = 64'd1 << (2 * FB - 2);
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		t = res;
		u = (64'd1 << FB) - t;
		t2 = fmul(t, t);
		u2 = fmul(u, u);
		case (palette_q)
			PAL_WARM: begin
				r = scale(fmul(fmul(t2, t), u), RED_K2);
				g = scale(fmul(u2, t2), GREEN_K2);
				b = scale(fmul(fmul(u2, u), t), BLUE_K2);
			end
			PAL_COOL: begin
				r = scale(fmul(u2, t), RED_K2);
				g = scale(fmul(u, t2), GREEN_K2);
				b = scale(fmul(t2, t), BLUE_K2);
			end
			default: begin
				r = scale(t2, RED_K2);
				g = scale(fmul(u, t), GREEN_K2);
				b = scale(u2, BLUE_K2);
			end
		endcase
		return ColourWidth'((r << 16) | (g << 8) | b);
	endfunction

	task automatic report_mismatch(input string what);
		errors++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	// Now and then, while idle_en is set, drop valid for a random idle gap
	task automatic idle_burst();
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_s.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
	endtask

	task automatic send_count(input logic [15:0] cnt);
		idle_burst();
		in_s.valid <= 1'b1;
		in_s.data <= cnt;
		@(posedge clk);
		while (!in_s.ready) @(posedge clk);
		colour_q.push_back(colour_of(cnt));
		words_sent++;
		@(negedge clk);
	endtask

	// Hold until the pipe is drained, then let it settle
	task automatic drain();
		in_s.valid <= 1'b0;
		while (colour_q.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [15:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MAX_ITER) limit_q = val;
		else palette_q = mode_t'(val[1:0]);
	endtask

	// Output stalls and the checker
	always @(negedge clk) begin
		if (idle_en && $urandom_range(0, 5) == 0) begin
			out_s.ready <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		out_s.ready <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && out_s.valid && out_s.ready) begin
			if (colour_q.size() == 0) begin
				report_mismatch($sformatf("unexpected colour %h", out_s.data));
			end else begin
				if (out_s.data !== colour_q[0])
					report_mismatch($sformatf("colour %h, predicted %h",
						out_s.data, colour_q[0]));
				void'(colour_q.pop_front());
				words_checked++;
			end
		end
	end

	task automatic test_reset_defaults();
		send_count(16'd0);
		send_count(16'd1);
		send_count(16'd50);
		send_count(16'd99);
		send_count(16'd100);
		send_count(16'hFFFF);
	endtask

	task automatic test_palettes();
		for (int m = 0; m < 4; m++) begin
			write_reg(REG_PALETTE, 16'(m));
			send_count(16'd0);
			send_count(16'd25);
			send_count(16'd64);
			send_count(16'd99);
		end
	endtask

	task automatic test_limit_extremes();
		write_reg(REG_MAX_ITER, 16'd0);
		send_count(16'd0);
		send_count(16'd7);
		write_reg(REG_MAX_ITER, 16'd1);
		send_count(16'd0);
		send_count(16'd1);
		write_reg(REG_MAX_ITER, 16'hFFFF);
		send_count(16'hFFFE);
		send_count(16'hFFFF);
		send_count(16'h5555);
		send_count(16'hAAAA);
	endtask

	task automatic test_random_counts(input int n);
		logic [15:0] cnt;
		for (int k = 0; k < n; k++) begin
			// Mostly counts below the limit; some at or above it
			case ($urandom_range(0, 9))
				0: cnt = limit_q;
				1: cnt = 16'($urandom);
				default: cnt = (limit_q == 0) ? 16'd0 : 16'($urandom_range(0, limit_q - 1));
			endcase
			send_count(cnt);
		end
	endtask

	task automatic test_random_settings();
		logic [15:0] lim;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: lim = 16'($urandom_range(1, 255));
				1: lim = 16'($urandom);
				2: lim = 16'hFFFF;
				default: lim = 16'($urandom_range(2, 20));
			endcase
			write_reg(REG_MAX_ITER, lim);
			write_reg(REG_PALETTE, 16'($urandom));
			test_random_counts(100);
		end
		idle_en = 1'b0;
		test_random_counts(150);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_s.valid = 1'b0;
		in_s.data = '0;
		out_s.ready = 1'b0;
		errors = 0;
		words_sent = 0;
		words_checked = 0;
		idle_en = 1'b1;
		limit_q = 16'd100;
		palette_q = PAL_WARM;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_reset_defaults();
		test_palettes();
		test_limit_extremes();
		test_random_settings();
		drain();
		$display("Covered %0d counts over all palettes and limits 0..65535, %0d colours checked.",
			words_sent, words_checked);
		if (errors == 0 && colour_q.size() == 0) begin
			$display("tb_escape_count_colour_palette_core passed");
		end else begin
			$display("tb_escape_count_colour_palette_core failed");
		end
		$finish;
	end
endmodule
